// ----- rtl/ngsc_pkg.sv -----
// Package holding the shared constants, types and codes of the n-gram counter.
package ngsc_pkg;

    localparam int MAX_WINDOW    = 8;
    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 48;
    localparam int POS_BITS      = $clog2(MAX_WINDOW);
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_BITS      = MAX_WINDOW * 64;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_FILLING = 3'd0,
        ST_HIT     = 3'd1,
        ST_NEW     = 3'd2,
        ST_DROPPED = 3'd3,
        ST_READOUT = 3'd4,
        ST_BAD     = 3'd5,
        ST_CLEARED = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_READ,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    shift_in;
        logic    scan_start;
        logic    scan_step;
        logic    do_hit;
        logic    do_new;
        logic    do_clear;
        logic    rd_start;
        logic    rd_step;
        logic    load_out;
        status_t out_status;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic window_full;
        logic scan_done;
        logic match;
        logic table_full;
        logic sel_ok;
        logic rd_last;
        logic out_busy;
    } stat_t;

endpackage

// ----- rtl/ngsc_datapath.sv -----
// Datapath of the n-gram counter: window, sequence table, scan and output register.
module ngsc_datapath
    import ngsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_data,
    input  logic [1:0]            in_operation,
    input  logic [63:0]           in_pointer_value,
    input  logic [5:0]            in_entry_select,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [2:0]            status,
    output logic [5:0]            entry_index,
    output logic [47:0]           entry_count,
    output logic [63:0]           key_word,
    output logic [2:0]            word_position,
    output logic [6:0]            used_entries,
    output logic                  last
);

    logic [3:0]               len_reg;
    logic [POS_BITS:0]        eff_len;
    logic [63:0]              win_reg [MAX_WINDOW];
    logic [POS_BITS:0]        fill_reg;
    logic [USED_BITS-1:0]     used_reg;
    logic [1:0]               op_reg;
    logic [63:0]              val_reg;
    logic [IDX_BITS-1:0]      sel_reg;
    logic [IDX_BITS:0]        scan_reg;
    logic [IDX_BITS-1:0]      hit_idx;
    logic [KEY_BITS-1:0]      keys_mem [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]    counts_mem [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]      key_rd_reg;
    logic [COUNT_BITS-1:0]    cnt_rd_reg;
    logic [KEY_BITS-1:0]      win_key;
    logic [KEY_BITS-1:0]      mask;
    logic [POS_BITS-1:0]      pos_reg;
    logic [IDX_BITS-1:0]      rd_addr;
    logic                     ov_reg;
    logic [2:0]               st_reg;
    logic [5:0]               idx_reg;
    logic [47:0]              cnt_reg;
    logic [63:0]              kw_reg;
    logic [2:0]               wp_reg;
    logic                     last_reg;
    logic [COUNT_BITS-1:0]    cnt_inc;

    always_comb
    begin
        if (len_reg == 4'd0)
            eff_len = (POS_BITS+1)'(1);
        else if (len_reg > 4'(MAX_WINDOW))
            eff_len = (POS_BITS+1)'(MAX_WINDOW);
        else
            eff_len = (POS_BITS+1)'(len_reg);
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            mask[j*64 +: 64] = (j < int'(eff_len)) ? {64{1'b1}} : 64'd0;
            win_key[j*64 +: 64] = win_reg[j];
        end
    end

    assign rd_addr = cmd.rd_start ? sel_reg : scan_reg[IDX_BITS-1:0];
    assign cnt_inc = (cnt_rd_reg == COUNT_MAX) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
    assign hit_idx = IDX_BITS'(scan_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step || cmd.rd_start)
        begin
            key_rd_reg <= keys_mem[rd_addr];
            cnt_rd_reg <= counts_mem[rd_addr];
        end
        if (cmd.do_hit)
            counts_mem[hit_idx] <= cnt_inc;
        if (cmd.do_new)
        begin
            keys_mem[used_reg[IDX_BITS-1:0]]   <= win_key & mask;
            counts_mem[used_reg[IDX_BITS-1:0]] <= COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= 4'd1;
            fill_reg  <= '0;
            used_reg  <= '0;
            scan_reg  <= '0;
            ov_reg    <= 1'b0;
            pos_reg   <= '0;
            for (int j = 0; j < MAX_WINDOW; j++)
                win_reg[j] <= 64'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg  <= cfg_data;
                fill_reg <= '0;
                used_reg <= '0;
                for (int j = 0; j < MAX_WINDOW; j++)
                    win_reg[j] <= 64'd0;
            end
            if (cmd.do_clear)
            begin
                fill_reg <= '0;
                used_reg <= '0;
                for (int j = 0; j < MAX_WINDOW; j++)
                    win_reg[j] <= 64'd0;
            end
            if (cmd.shift_in)
            begin
                if (fill_reg < eff_len)
                begin
                    win_reg[fill_reg[POS_BITS-1:0]] <= val_reg;
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    for (int j = 0; j < MAX_WINDOW - 1; j++)
                        if (j + 1 < int'(eff_len))
                            win_reg[j] <= win_reg[j+1];
                    win_reg[POS_BITS'(eff_len - 1'b1)] <= val_reg;
                end
            end
            if (cmd.scan_start)
                scan_reg <= '0;
            if (cmd.scan_step)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.do_new)
                used_reg <= used_reg + 1'b1;
            if (cmd.rd_start)
                pos_reg <= '0;
            if (cmd.rd_step)
                pos_reg <= pos_reg + 1'b1;
            if (cmd.load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_operation;
            val_reg <= in_pointer_value;
            sel_reg <= in_entry_select;
        end
        if (cmd.load_out)
        begin
            st_reg   <= cmd.out_status;
            last_reg <= cmd.out_last;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            kw_reg   <= '0;
            wp_reg   <= '0;
            case (cmd.out_status)
                ST_HIT:
                begin
                    idx_reg <= 6'(hit_idx);
                    cnt_reg <= 48'(cnt_inc);
                end
                ST_NEW:
                begin
                    idx_reg <= 6'(used_reg);
                    cnt_reg <= 48'd1;
                end
                ST_READOUT:
                begin
                    idx_reg <= 6'(sel_reg);
                    cnt_reg <= 48'(cnt_rd_reg);
                    kw_reg  <= key_rd_reg[pos_reg*64 +: 64];
                    wp_reg  <= 3'(pos_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.op          = op_t'(op_reg);
    assign stat.window_full = (fill_reg == eff_len);
    assign stat.scan_done   = stat.match || (scan_reg == (IDX_BITS+1)'(used_reg));
    assign stat.match       = (scan_reg != '0) && ((key_rd_reg & mask) == (win_key & mask));
    assign stat.table_full  = (used_reg == USED_BITS'(TABLE_ENTRIES));
    assign stat.sel_ok      = (USED_BITS'(sel_reg) < used_reg);
    assign stat.rd_last     = ((POS_BITS+1)'(pos_reg) + 1'b1 == eff_len);
    assign stat.out_busy    = ov_reg && out_stall;

    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign entry_index   = idx_reg;
    assign entry_count   = cnt_reg;
    assign key_word      = kw_reg;
    assign word_position = wp_reg;
    assign used_entries  = 7'(used_reg);
    assign last          = last_reg;

endmodule

// ----- rtl/ngsc_control.sv -----
// Controller state machine of the n-gram counter.
module ngsc_control
    import ngsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = ST_FILLING;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                case (stat.op)
                    OP_PUSH:
                    begin
                        cmd.shift_in   = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    OP_READ:
                        state_next = S_READ;
                    OP_CLEAR:
                        state_next = S_OUT;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                if (!stat.window_full)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_FILLING;
                        cmd.out_last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (stat.scan_done)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_last = 1'b1;
                        if (stat.match)
                        begin
                            cmd.do_hit     = 1'b1;
                            cmd.out_status = ST_HIT;
                        end
                        else if (stat.table_full)
                            cmd.out_status = ST_DROPPED;
                        else
                        begin
                            cmd.do_new     = 1'b1;
                            cmd.out_status = ST_NEW;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_READ:
            begin
                if (!stat.sel_ok)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_BAD;
                        cmd.out_last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.op == OP_CLEAR)
                    begin
                        cmd.do_clear   = 1'b1;
                        cmd.out_status = ST_CLEARED;
                        cmd.out_last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_status = ST_READOUT;
                        cmd.out_last   = stat.rd_last;
                        if (stat.rd_last)
                            state_next = S_IDLE;
                        else
                            cmd.rd_step = 1'b1;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_hit || cmd.do_new) |-> cmd.load_out)
        else $error("table update without a result word");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_hit && cmd.do_new))
        else $error("hit and new entry together");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_UPDATE)
        else $error("captured word not decoded");

endmodule

// ----- rtl/ngram_sequence_counter_unit.sv -----
// A full-window push scans the used entries, stopping at a match, then loads its result word.
// Input words are taken one at a time; in_stall stays high until the controller is idle again.
// A read gives one result word per window word, one result word a cycle while the output is not stalled.
// A clear, a filling push or a bad read gives one result word.
// Reset empties the window and the table and sets window_len to one; no clearing pass.
// Top level of the n-gram counter joining controller and datapath.
module ngram_sequence_counter_unit
    import ngsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [63:0] pointer_value,
    input  logic [5:0]  entry_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  entry_index,
    output logic [47:0] entry_count,
    output logic [63:0] key_word,
    output logic [2:0]  word_position,
    output logic [6:0]  used_entries,
    output logic        last
);

    cmd_t  cmd;
    stat_t stat;

    ngsc_control u_control (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ngsc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_operation     (operation),
        .in_pointer_value (pointer_value),
        .in_entry_select  (entry_select),
        .cmd              (cmd),
        .stat             (stat),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .status           (status),
        .entry_index      (entry_index),
        .entry_count      (entry_count),
        .key_word         (key_word),
        .word_position    (word_position),
        .used_entries     (used_entries),
        .last             (last)
    );

endmodule

// ----- verif/tb_ngram_sequence_counter_unit.sv -----
// Self-checking testbench of the n-gram sequence counter: random and directed words against a predictor.
`timescale 1ns / 100ps

module tb_ngram_sequence_counter_unit;
    import ngsc_pkg::*;

    typedef struct {
        op_t         op;
        logic [63:0] ptr;
        logic [5:0]  sel;
        bit          is_cfg;
        logic [3:0]  cfg;
        bit          drain;
    } item_t;

    typedef struct {
        status_t     st;
        logic [5:0]  idx;
        logic [47:0] cnt;
        logic [63:0] key;
        logic [2:0]  pos;
        logic [6:0]  used;
        logic        lst;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [63:0] pointer_value;
    logic [5:0]  entry_select;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [47:0] entry_count;
    logic [63:0] key_word;
    logic [2:0]  word_position;
    logic [6:0]  used_entries;
    logic        last;

    item_t   pending_words[$];
    result_t expected_results[$];
    int      errors;
    int      idle_cycles;
    bit      stimulus_done;

    logic [3:0]  seq_len;
    logic [63:0] win[MAX_WINDOW];
    int          win_fill;
    logic [63:0] stored_keys[TABLE_ENTRIES][MAX_WINDOW];
    logic [47:0] stored_counts[TABLE_ENTRIES];
    int          stored_used;

    ngram_sequence_counter_unit i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .pointer_value(pointer_value), .entry_select(entry_select),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .entry_index(entry_index), .entry_count(entry_count), .key_word(key_word),
        .word_position(word_position), .used_entries(used_entries), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int active_len();
        if (seq_len == 0)
            return 1;
        if (seq_len > MAX_WINDOW)
            return MAX_WINDOW;
        return seq_len;
    endfunction

    function automatic void empty_table();
        for (int j = 0; j < MAX_WINDOW; j++)
            win[j] = '0;
        win_fill = 0;
        stored_used = 0;
    endfunction

    function automatic void add_result(status_t st, int idx, logic [47:0] cnt,
                                       logic [63:0] key, int pos, bit lst);
        result_t r;
        r.st = st;
        r.idx = 6'(idx);
        r.cnt = cnt;
        r.key = key;
        r.pos = 3'(pos);
        r.used = 7'(stored_used);
        r.lst = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_counts(item_t it);
        int  n;
        bit  same;
        bit  found;
        n = active_len();
        found = 0;
        case (it.op)
            OP_PUSH:
            begin
                if (win_fill < n)
                begin
                    win[win_fill] = it.ptr;
                    win_fill++;
                end
                else
                begin
                    for (int j = 1; j < n; j++)
                        win[j-1] = win[j];
                    win[n-1] = it.ptr;
                end
                if (win_fill < n)
                    add_result(ST_FILLING, 0, 0, 0, 0, 1);
                else
                begin
                    for (int i = 0; i < stored_used && !found; i++)
                    begin
                        same = 1;
                        for (int j = 0; j < n; j++)
                            if (stored_keys[i][j] !== win[j])
                                same = 0;
                        if (same)
                        begin
                            found = 1;
                            if (stored_counts[i] != COUNT_MAX)
                                stored_counts[i]++;
                            add_result(ST_HIT, i, stored_counts[i], 0, 0, 1);
                        end
                    end
                    if (!found)
                    begin
                        if (stored_used >= TABLE_ENTRIES)
                            add_result(ST_DROPPED, 0, 0, 0, 0, 1);
                        else
                        begin
                            for (int j = 0; j < MAX_WINDOW; j++)
                                stored_keys[stored_used][j] = (j < n) ? win[j] : '0;
                            stored_counts[stored_used] = 1;
                            stored_used++;
                            add_result(ST_NEW, stored_used - 1, 1, 0, 0, 1);
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (it.sel >= stored_used)
                    add_result(ST_BAD, 0, 0, 0, 0, 1);
                else
                    for (int j = 0; j < n; j++)
                        add_result(ST_READOUT, it.sel, stored_counts[it.sel],
                                   stored_keys[it.sel][j], j, j == n - 1);
            end
            OP_CLEAR:
            begin
                empty_table();
                add_result(ST_CLEARED, 0, 0, 0, 0, 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    int  burst_left;
    int  gap_left;
    bit  draining;
    int  drain_wait;
    bit  in_taken;
    bit  valid_n;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            valid_n = in_valid;
            if (in_taken)
                valid_n = 1'b0;
            if (cfg_we)
                cfg_we <= 1'b0;
            if ((!in_valid || in_taken) && !cfg_we && pending_words.size() > 0)
            begin
                if (pending_words[0].drain || pending_words[0].is_cfg)
                begin
                    valid_n = 1'b0;
                    if (expected_results.size() == 0)
                    begin
                        if (drain_wait < 80)
                            drain_wait++;
                        else
                        begin
                            drain_wait = 0;
                            if (pending_words[0].is_cfg)
                            begin
                                cfg_we <= 1'b1;
                                cfg_data <= pending_words[0].cfg;
                                seq_len = pending_words[0].cfg;
                                empty_table();
                            end
                            void'(pending_words.pop_front());
                        end
                    end
                    else
                        drain_wait = 0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    valid_n = 1'b0;
                end
                else
                begin
                    item_t it;
                    it = pending_words.pop_front();
                    valid_n = 1'b1;
                    operation <= it.op;
                    pointer_value <= it.ptr;
                    entry_select <= it.sel;
                    predict_counts(it);
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                    end
                end
            end
            in_valid <= valid_n;
            if (pending_words.size() == 0 && !valid_n)
                stimulus_done <= 1'b1;
            case ($urandom_range(0, 3))
                0: out_stall <= ($urandom_range(0, 1) == 1);
                1: out_stall <= 1'b0;
                default: out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word, status %0d", status);
                    errors++;
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        errors++;
                    end
                    if (entry_index !== e.idx)
                    begin
                        $error("entry_index: expected %0d, got %0d", e.idx, entry_index);
                        errors++;
                    end
                    if (entry_count !== e.cnt)
                    begin
                        $error("entry_count: expected %0d, got %0d", e.cnt, entry_count);
                        errors++;
                    end
                    if (key_word !== e.key)
                    begin
                        $error("key_word: expected %h, got %h", e.key, key_word);
                        errors++;
                    end
                    if (word_position !== e.pos)
                    begin
                        $error("word_position: expected %0d, got %0d", e.pos, word_position);
                        errors++;
                    end
                    if (used_entries !== e.used)
                    begin
                        $error("used_entries: expected %0d, got %0d", e.used, used_entries);
                        errors++;
                    end
                    if (last !== e.lst)
                    begin
                        $error("last: expected %0d, got %0d", e.lst, last);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic void add_word(op_t op, logic [63:0] ptr, logic [5:0] sel);
        item_t it;
        it.op = op;
        it.ptr = ptr;
        it.sel = sel;
        it.is_cfg = 0;
        it.cfg = 0;
        it.drain = 0;
        pending_words.push_back(it);
    endfunction

    function automatic void add_cfg(logic [3:0] v);
        item_t it;
        it.op = OP_NONE;
        it.ptr = 0;
        it.sel = 0;
        it.is_cfg = 1;
        it.cfg = v;
        it.drain = 0;
        pending_words.push_back(it);
    endfunction

    function automatic void add_pause();
        item_t it;
        it.op = OP_NONE;
        it.ptr = 0;
        it.sel = 0;
        it.is_cfg = 0;
        it.cfg = 0;
        it.drain = 1;
        pending_words.push_back(it);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void random_phase(int words, int alphabet);
        logic [63:0] pool[4];
        int          r;
        for (int k = 0; k < 4; k++)
            pool[k] = ($urandom_range(0, 3) == 0) ? rand64() : 64'(k);
        for (int k = 0; k < words; k++)
        begin
            r = $urandom_range(0, 19);
            if (r < 14)
                add_word(OP_PUSH, (r < 12) ? pool[$urandom_range(0, alphabet - 1)] : rand64(),
                         6'($urandom));
            else if (r < 18)
                add_word(OP_READ, rand64(), ($urandom_range(0, 1) == 1) ?
                         6'($urandom_range(0, 7)) : 6'($urandom));
            else if (r == 18)
                add_word(OP_NONE, rand64(), 6'($urandom));
            else
                add_word(OP_CLEAR, rand64(), 6'($urandom));
        end
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_NONE;
        pointer_value = '0;
        entry_select = '0;
        out_stall = 1'b0;
        errors = 0;
        idle_cycles = 0;
        stimulus_done = 0;
        burst_left = 0;
        gap_left = 0;
        drain_wait = 0;
        in_taken = 0;
        valid_n = 0;
        seq_len = 1;
        empty_table();

        add_word(OP_READ, '0, 6'd0);
        add_word(OP_PUSH, '1, 6'd63);
        add_word(OP_PUSH, '0, 6'd0);
        add_word(OP_PUSH, '1, 6'd0);
        add_word(OP_READ, '0, 6'd0);
        add_word(OP_READ, '0, 6'd63);
        add_word(OP_NONE, '1, 6'd5);
        add_word(OP_CLEAR, '1, 6'd63);
        add_word(OP_READ, '0, 6'd0);
        add_cfg(4'd8);
        for (int k = 0; k < 10; k++)
            add_word(OP_PUSH, 64'(k % 9), 6'd0);
        add_word(OP_READ, '0, 6'd1);
        add_cfg(4'd0);
        for (int k = 0; k < 66; k++)
            add_word(OP_PUSH, 64'h5555_0000_0000_0000 + k, 6'd0);
        add_word(OP_PUSH, 64'h5555_0000_0000_0000, 6'd0);
        add_word(OP_READ, '0, 6'd63);
        add_pause();
        add_cfg(4'd15);
        random_phase(20, 3);
        add_pause();
        add_cfg(4'd2);
        random_phase(25, 2);
        add_cfg(4'd3);
        random_phase(20, 3);
        add_cfg(4'd1);
        random_phase(25, 4);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= 5000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- ngram_sequence_counter_unit.f -----
rtl/ngsc_pkg.sv
rtl/ngsc_datapath.sv
rtl/ngsc_control.sv
rtl/ngram_sequence_counter_unit.sv
verif/tb_ngram_sequence_counter_unit.sv
